// File: hdl/pssc_pkg.sv
package pssc_pkg;

    // fixed point: 2^-22 degree, a 1/64 degree heading sits 16 bits up
    localparam int FRAC_BITS  = 22;
    localparam int HEAD_SHIFT = 16;

    // datapath widths
    localparam int EST_W  = 40;
    localparam int GAP_W  = EST_W + 1;
    localparam int DIFF_W = 43;
    localparam int GOAL_W = 25;
    localparam int PTR_W  = 9;
    localparam int STEER_W = 8;

    // angle limits in 2^-22 degree
    localparam logic signed [DIFF_W-1:0] HALF_TURN     = DIFF_W'(180 * (2 ** FRAC_BITS));
    localparam logic signed [DIFF_W-1:0] HALF_TURN_NEG = -HALF_TURN;
    localparam logic signed [DIFF_W-1:0] FULL_TURN     = DIFF_W'(360 * (2 ** FRAC_BITS));
    localparam logic signed [DIFF_W-1:0] STEER_LIM     = DIFF_W'(80 * (2 ** FRAC_BITS));
    localparam logic signed [DIFF_W-1:0] STEER_LIM_NEG = -STEER_LIM;

    // goal distances below which the heading error is boosted
    localparam logic [GOAL_W-1:0] GOAL_TRIPLE_BELOW = 25'd5;
    localparam logic [GOAL_W-1:0] GOAL_DOUBLE_BELOW = 25'd10;

    // configuration
    localparam logic [15:0] TURN_RATE_RESET = 16'd1024;
    localparam logic        REG_TURN_RATE   = 1'b0;

    // request kinds
    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } item_op_t;

    // controller states
    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_DISPATCH,
        ST_CHECK,
        ST_READ,
        ST_ENTER,
        ST_WRAP,
        ST_SCALE,
        ST_CLAMP,
        ST_TRUNC,
        ST_MUL2,
        ST_INTEG,
        ST_GAP_DIFF,
        ST_GAP_CMP,
        ST_DONE
    } ctrl_state_t;

    // datapath operations
    typedef enum logic [4:0]
    {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD,
        DP_START,
        DP_CLR_PEND,
        DP_READ,
        DP_ENTER,
        DP_WRAP,
        DP_SCALE,
        DP_CLAMP,
        DP_TRUNC,
        DP_HALT_MOVE,
        DP_ADVANCE,
        DP_END_PATH,
        DP_MUL1,
        DP_MUL2,
        DP_INTEG,
        DP_GAP_DIFF,
        DP_GAP_CMP
    } dp_op_t;

    typedef struct packed
    {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed
    {
        logic is_tick;
        logic pending;
        logic total_zero;
        logic manual;
        logic moving;
        logic running;
        logic reached;
        logic at_last;
        logic steer_zero;
        logic first;
    } dp_status_t;

endpackage

// File: hdl/pssc_regs.sv
module pssc_regs
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] turn_rate
);

    logic        wr_en;
    logic        sel_turn_rate;
    logic [15:0] turn_rate_reg;

    // word decode, byte offset ignored
    assign sel_turn_rate = (paddr[2] == pssc_pkg::REG_TURN_RATE);
    assign wr_en         = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_rate_reg <= pssc_pkg::TURN_RATE_RESET;
        end
        else if (wr_en && sel_turn_rate)
        begin
            turn_rate_reg <= pwdata[15:0];
        end
    end

    // read back
    assign prdata    = sel_turn_rate ? {16'b0, turn_rate_reg} : 32'b0;
    assign pready    = 1'b1;
    assign turn_rate = turn_rate_reg;

endmodule

// File: hdl/pssc_ctrl.sv
module pssc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  pssc_pkg::dp_status_t status,
    output pssc_pkg::dp_cmd_t    cmd
);

    pssc_pkg::ctrl_state_t state_reg;
    pssc_pkg::ctrl_state_t state_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic                  out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pssc_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pssc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = pssc_pkg::ST_DISPATCH;
                end
            end
            pssc_pkg::ST_DISPATCH:
            begin
                priority if (!status.is_tick)
                begin
                    state_next = pssc_pkg::ST_DONE;
                end
                else if (status.pending && !status.total_zero)
                begin
                    state_next = pssc_pkg::ST_READ;
                end
                else
                begin
                    state_next = pssc_pkg::ST_CHECK;
                end
            end
            pssc_pkg::ST_CHECK:
            begin
                priority if (status.manual || !status.moving || !status.running)
                begin
                    state_next = pssc_pkg::ST_DONE;
                end
                else if (status.reached)
                begin
                    state_next = status.at_last ? pssc_pkg::ST_DONE : pssc_pkg::ST_READ;
                end
                else if (!status.steer_zero)
                begin
                    state_next = pssc_pkg::ST_MUL2;
                end
                else
                begin
                    state_next = pssc_pkg::ST_DONE;
                end
            end
            pssc_pkg::ST_READ:     state_next = pssc_pkg::ST_ENTER;
            pssc_pkg::ST_ENTER:
            begin
                // step 0 comes from a path start and goes on to the motion check
                state_next = status.first ? pssc_pkg::ST_CHECK : pssc_pkg::ST_WRAP;
            end
            pssc_pkg::ST_WRAP:     state_next = pssc_pkg::ST_SCALE;
            pssc_pkg::ST_SCALE:    state_next = pssc_pkg::ST_CLAMP;
            pssc_pkg::ST_CLAMP:    state_next = pssc_pkg::ST_TRUNC;
            pssc_pkg::ST_TRUNC:    state_next = pssc_pkg::ST_DONE;
            pssc_pkg::ST_MUL2:     state_next = pssc_pkg::ST_INTEG;
            pssc_pkg::ST_INTEG:    state_next = pssc_pkg::ST_GAP_DIFF;
            pssc_pkg::ST_GAP_DIFF: state_next = pssc_pkg::ST_GAP_CMP;
            pssc_pkg::ST_GAP_CMP:  state_next = pssc_pkg::ST_DONE;
            pssc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = pssc_pkg::ST_IDLE;
                end
            end
            default:               state_next = pssc_pkg::ST_IDLE;
        endcase
    end

    // datapath commands and handshake outputs
    always_comb
    begin
        cmd.op       = pssc_pkg::DP_NOP;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            pssc_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op = pssc_pkg::DP_CAPTURE;
                end
            end
            pssc_pkg::ST_DISPATCH:
            begin
                priority if (!status.is_tick)
                begin
                    cmd.op = pssc_pkg::DP_LOAD;
                end
                else if (status.pending && !status.total_zero)
                begin
                    cmd.op = pssc_pkg::DP_START;
                end
                else if (status.pending)
                begin
                    cmd.op = pssc_pkg::DP_CLR_PEND;
                end
                else
                begin
                    cmd.op = pssc_pkg::DP_NOP;
                end
            end
            pssc_pkg::ST_CHECK:
            begin
                priority if (status.manual)
                begin
                    cmd.op = pssc_pkg::DP_NOP;
                end
                else if (!status.moving || !status.running)
                begin
                    cmd.op = pssc_pkg::DP_HALT_MOVE;
                end
                else if (status.reached)
                begin
                    cmd.op = status.at_last ? pssc_pkg::DP_END_PATH : pssc_pkg::DP_ADVANCE;
                end
                else if (!status.steer_zero)
                begin
                    cmd.op = pssc_pkg::DP_MUL1;
                end
                else
                begin
                    cmd.op = pssc_pkg::DP_NOP;
                end
            end
            pssc_pkg::ST_READ:     cmd.op = pssc_pkg::DP_READ;
            pssc_pkg::ST_ENTER:    cmd.op = pssc_pkg::DP_ENTER;
            pssc_pkg::ST_WRAP:     cmd.op = pssc_pkg::DP_WRAP;
            pssc_pkg::ST_SCALE:    cmd.op = pssc_pkg::DP_SCALE;
            pssc_pkg::ST_CLAMP:    cmd.op = pssc_pkg::DP_CLAMP;
            pssc_pkg::ST_TRUNC:    cmd.op = pssc_pkg::DP_TRUNC;
            pssc_pkg::ST_MUL2:     cmd.op = pssc_pkg::DP_MUL2;
            pssc_pkg::ST_INTEG:    cmd.op = pssc_pkg::DP_INTEG;
            pssc_pkg::ST_GAP_DIFF: cmd.op = pssc_pkg::DP_GAP_DIFF;
            pssc_pkg::ST_GAP_CMP:  cmd.op = pssc_pkg::DP_GAP_CMP;
            pssc_pkg::ST_DONE:     cmd.out_load = out_free;
            default:               cmd.op = pssc_pkg::DP_NOP;
        endcase

        // output register holds a result until taken
        if (cmd.out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    assign req_ready = (state_reg == pssc_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

// File: hdl/pssc_dp.sv
module pssc_dp
#(
    parameter int STEP_DEPTH = 256
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pssc_pkg::dp_cmd_t            cmd,
    output pssc_pkg::dp_status_t         status,
    input  logic [15:0]                  turn_rate,
    input  logic                         op,
    input  logic [7:0]                   load_index,
    input  logic                         load_last,
    input  logic [15:0]                  load_distance_mm,
    input  logic signed [15:0]           load_heading,
    input  logic [15:0]                  delta_time_us,
    input  logic [23:0]                  travelled_mm,
    input  logic                         manual_mode,
    input  logic                         moving_in,
    output logic signed [7:0]            steer,
    output logic                         moving_out,
    output logic                         path_running,
    output logic [pssc_pkg::PTR_W-1:0]   current_step
);

    localparam int ADDR_W = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;
    localparam int EST_W  = pssc_pkg::EST_W;
    localparam int GAP_W  = pssc_pkg::GAP_W;
    localparam int DIFF_W = pssc_pkg::DIFF_W;
    localparam int GOAL_W = pssc_pkg::GOAL_W;
    localparam int PTR_W  = pssc_pkg::PTR_W;
    localparam int SW     = pssc_pkg::STEER_W;
    localparam int HS     = pssc_pkg::HEAD_SHIFT;
    localparam int FB     = pssc_pkg::FRAC_BITS;

    // captured request
    pssc_pkg::item_op_t op_reg;
    logic [7:0]         index_reg;
    logic               last_reg;
    logic [15:0]        dist_reg;
    logic [15:0]        head_reg;
    logic [15:0]        dt_reg;
    logic [23:0]        travelled_reg;
    logic               manual_reg;

    // step table
    logic [31:0]        step_mem [STEP_DEPTH];
    logic [31:0]        rd_reg;

    // path state
    logic [PTR_W-1:0]         total_reg, total_next;
    logic [PTR_W-1:0]         pointer_reg, pointer_next;
    logic                     pending_reg, pending_next;
    logic                     running_reg, running_next;
    logic                     moving_reg, moving_next;
    logic [GOAL_W-1:0]        goal_reg, goal_next;
    logic [15:0]              goal_head_reg, goal_head_next;
    logic signed [EST_W-1:0]  est_reg, est_next;
    logic [EST_W-1:0]         prev_gap_reg, prev_gap_next;
    logic signed [SW-1:0]     steer_reg, steer_next;

    // working values
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [31:0]              prod_reg, prod_next;
    logic signed [EST_W-1:0]  dprod_reg, dprod_next;
    logic signed [GAP_W-1:0]  gdiff_reg, gdiff_next;

    // result register
    logic signed [SW-1:0]     out_steer_reg;
    logic                     out_moving_reg;
    logic                     out_running_reg;
    logic [PTR_W-1:0]         out_step_reg;

    logic [ADDR_W+7:0]        idx_ext;
    logic [ADDR_W+8:0]        ptr_ext;
    logic                     idx_ok;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic [15:0]              rd_len;
    logic [15:0]              rd_head;
    logic signed [EST_W-1:0]  rd_target;
    logic signed [EST_W-1:0]  goal_target;
    logic [PTR_W-1:0]         total_new;
    logic [DIFF_W-1:0]        diff_mag;
    logic [GAP_W-1:0]         gap_mag;
    logic [SW-1:0]            steer_mag;
    logic signed [EST_W:0]    mul_full;

    // table addressing
    assign idx_ext   = {{ADDR_W{1'b0}}, index_reg};
    assign idx_ok    = (idx_ext < (ADDR_W+8)'(STEP_DEPTH));
    assign wr_addr   = idx_ext[ADDR_W-1:0];
    assign ptr_ext   = {{ADDR_W{1'b0}}, pointer_reg};
    assign rd_addr   = ptr_ext[ADDR_W-1:0];
    assign total_new = {1'b0, index_reg} + 9'd1;

    // headings placed in the 2^-22 degree scale
    assign rd_len      = rd_reg[31:16];
    assign rd_head     = rd_reg[15:0];
    assign rd_target   = {{(EST_W-16-HS){rd_head[15]}}, rd_head, {HS{1'b0}}};
    assign goal_target = {{(EST_W-16-HS){goal_head_reg[15]}}, goal_head_reg, {HS{1'b0}}};

    // magnitudes
    assign diff_mag  = diff_reg[DIFF_W-1] ? (-diff_reg) : diff_reg;
    assign gap_mag   = gdiff_reg[GAP_W-1] ? (-gdiff_reg) : gdiff_reg;
    assign steer_mag = diff_mag[FB +: SW];

    // rate times steering, sign carried by the steering value
    assign mul_full = $signed({1'b0, prod_reg}) * steer_reg;

    // capture request payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == pssc_pkg::DP_CAPTURE)
        begin
            op_reg        <= pssc_pkg::item_op_t'(op);
            index_reg     <= load_index;
            last_reg      <= load_last;
            dist_reg      <= load_distance_mm;
            head_reg      <= load_heading;
            dt_reg        <= delta_time_us;
            travelled_reg <= travelled_mm;
            manual_reg    <= manual_mode;
        end
    end

    // step table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.op == pssc_pkg::DP_LOAD && idx_ok)
        begin
            step_mem[wr_addr] <= {dist_reg, head_reg};
        end
        if (cmd.op == pssc_pkg::DP_READ)
        begin
            rd_reg <= step_mem[rd_addr];
        end
    end

    // path state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            pointer_reg   <= '0;
            pending_reg   <= 1'b0;
            running_reg   <= 1'b0;
            goal_reg      <= '0;
            goal_head_reg <= '0;
            est_reg       <= '0;
            prev_gap_reg  <= '0;
            steer_reg     <= '0;
        end
        else
        begin
            total_reg     <= total_next;
            pointer_reg   <= pointer_next;
            pending_reg   <= pending_next;
            running_reg   <= running_next;
            goal_reg      <= goal_next;
            goal_head_reg <= goal_head_next;
            est_reg       <= est_next;
            prev_gap_reg  <= prev_gap_next;
            steer_reg     <= steer_next;
        end
    end

    // working registers and result register
    always_ff @(posedge clk)
    begin
        moving_reg <= moving_next;
        diff_reg   <= diff_next;
        prod_reg   <= prod_next;
        dprod_reg  <= dprod_next;
        gdiff_reg  <= gdiff_next;
        if (cmd.out_load)
        begin
            out_steer_reg   <= steer_reg;
            out_moving_reg  <= moving_reg;
            out_running_reg <= running_reg;
            out_step_reg    <= pointer_reg;
        end
    end

    // operation decode
    always_comb
    begin
        total_next     = total_reg;
        pointer_next   = pointer_reg;
        pending_next   = pending_reg;
        running_next   = running_reg;
        moving_next    = moving_reg;
        goal_next      = goal_reg;
        goal_head_next = goal_head_reg;
        est_next       = est_reg;
        prev_gap_next  = prev_gap_reg;
        steer_next     = steer_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        dprod_next     = dprod_reg;
        gdiff_next     = gdiff_reg;
        unique case (cmd.op)
            pssc_pkg::DP_CAPTURE:
            begin
                moving_next = moving_in;
            end
            pssc_pkg::DP_LOAD:
            begin
                // out of range loads leave the path alone
                if (idx_ok && last_reg)
                begin
                    total_next   = total_new;
                    pending_next = 1'b1;
                end
                moving_next = 1'b0;
            end
            pssc_pkg::DP_START:
            begin
                pointer_next = '0;
                running_next = 1'b1;
                pending_next = 1'b0;
            end
            pssc_pkg::DP_CLR_PEND:
            begin
                pending_next = 1'b0;
            end
            pssc_pkg::DP_ENTER:
            begin
                goal_next      = {1'b0, travelled_reg} + {9'b0, rd_len};
                goal_head_next = rd_head;
                if (pointer_reg == '0)
                begin
                    // first step snaps the estimate and drives straight
                    est_next   = rd_target;
                    steer_next = '0;
                end
                else
                begin
                    diff_next = {{(DIFF_W-EST_W){est_reg[EST_W-1]}}, est_reg}
                              - {{(DIFF_W-EST_W){rd_target[EST_W-1]}}, rd_target};
                end
            end
            pssc_pkg::DP_WRAP:
            begin
                prev_gap_next = diff_mag[EST_W-1:0];
                priority if (diff_reg > pssc_pkg::HALF_TURN)
                begin
                    diff_next = diff_reg - pssc_pkg::FULL_TURN;
                end
                else if (diff_reg < pssc_pkg::HALF_TURN_NEG)
                begin
                    diff_next = diff_reg + pssc_pkg::FULL_TURN;
                end
                else
                begin
                    diff_next = diff_reg;
                end
            end
            pssc_pkg::DP_SCALE:
            begin
                priority if (goal_reg < pssc_pkg::GOAL_TRIPLE_BELOW)
                begin
                    diff_next = diff_reg + (diff_reg <<< 1);
                end
                else if (goal_reg < pssc_pkg::GOAL_DOUBLE_BELOW)
                begin
                    diff_next = diff_reg <<< 1;
                end
                else
                begin
                    diff_next = diff_reg;
                end
            end
            pssc_pkg::DP_CLAMP:
            begin
                priority if (diff_reg > pssc_pkg::STEER_LIM)
                begin
                    diff_next = pssc_pkg::STEER_LIM;
                end
                else if (diff_reg < pssc_pkg::STEER_LIM_NEG)
                begin
                    diff_next = pssc_pkg::STEER_LIM_NEG;
                end
                else
                begin
                    diff_next = diff_reg;
                end
            end
            pssc_pkg::DP_TRUNC:
            begin
                // whole degrees, rounded toward zero
                steer_next = diff_reg[DIFF_W-1] ? (8'd0 - steer_mag) : steer_mag;
            end
            pssc_pkg::DP_HALT_MOVE:
            begin
                moving_next = 1'b0;
            end
            pssc_pkg::DP_ADVANCE:
            begin
                pointer_next = pointer_reg + 9'd1;
            end
            pssc_pkg::DP_END_PATH:
            begin
                pointer_next = pointer_reg + 9'd1;
                running_next = 1'b0;
                moving_next  = 1'b0;
            end
            pssc_pkg::DP_MUL1:
            begin
                prod_next = {16'b0, turn_rate} * {16'b0, dt_reg};
            end
            pssc_pkg::DP_MUL2:
            begin
                dprod_next = mul_full[EST_W-1:0];
            end
            pssc_pkg::DP_INTEG:
            begin
                est_next = est_reg - dprod_reg;
            end
            pssc_pkg::DP_GAP_DIFF:
            begin
                gdiff_next = {goal_target[EST_W-1], goal_target} - {est_reg[EST_W-1], est_reg};
            end
            pssc_pkg::DP_GAP_CMP:
            begin
                // overshoot: heading error grew, centre the steering
                if (gap_mag[EST_W-1:0] > prev_gap_reg)
                begin
                    est_next   = goal_target;
                    steer_next = '0;
                end
                else
                begin
                    prev_gap_next = gap_mag[EST_W-1:0];
                end
            end
            default:
            begin
                moving_next = moving_reg;
            end
        endcase
    end

    // status to the controller
    assign status.is_tick    = (op_reg == pssc_pkg::OP_TICK);
    assign status.pending    = pending_reg;
    assign status.total_zero = (total_reg == '0);
    assign status.manual     = manual_reg;
    assign status.moving     = moving_reg;
    assign status.running    = running_reg;
    assign status.reached    = ({1'b0, travelled_reg} >= goal_reg);
    assign status.at_last    = (({1'b0, pointer_reg} + 10'd1) >= {1'b0, total_reg});
    assign status.steer_zero = (steer_reg == '0);
    assign status.first      = (pointer_reg == '0);

    assign steer        = out_steer_reg;
    assign moving_out   = out_moving_reg;
    assign path_running = out_running_reg;
    assign current_step = out_step_reg;

endmodule

// File: hdl/path_step_steering_controller_top.sv
// Path step steering controller. A load request writes one path step
// (distance, heading) into a STEP_DEPTH entry table; the load marked last
// arms the path, and the next tick starts it at step 0. Every request gives
// one result: steer in whole degrees (-80..80), moving_out, path_running
// and current_step. Requests are handled one at a time by a sequencer. A
// tick that integrates heading runs the two chained multiplies and the wide
// subtract and compare behind them; a tick that enters a new step uses the
// single registered table read port and the five step steering pipeline
// (difference, wrap, boost, clamp, truncate); a tick that starts a path can
// at once pass a zero length first step and enter the next. The result sits
// in an output register, so the next request is taken while it waits.
module path_step_steering_controller_top
#(
    parameter int STEP_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               req_valid,
    output logic               req_ready,
    input  logic               op,
    input  logic [7:0]         load_index,
    input  logic               load_last,
    input  logic [15:0]        load_distance_mm,
    input  logic signed [15:0] load_heading,
    input  logic [15:0]        delta_time_us,
    input  logic [23:0]        travelled_mm,
    input  logic               manual_mode,
    input  logic               moving_in,

    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic signed [7:0]  steer,
    output logic               moving_out,
    output logic               path_running,
    output logic [8:0]         current_step
);

    logic [15:0]          turn_rate;
    pssc_pkg::dp_cmd_t    cmd;
    pssc_pkg::dp_status_t status;

    // configuration registers
    pssc_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .turn_rate (turn_rate)
    );

    // sequencer
    pssc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // step table and steering arithmetic
    pssc_dp
    #(
        .STEP_DEPTH (STEP_DEPTH)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .turn_rate        (turn_rate),
        .op               (op),
        .load_index       (load_index),
        .load_last        (load_last),
        .load_distance_mm (load_distance_mm),
        .load_heading     (load_heading),
        .delta_time_us    (delta_time_us),
        .travelled_mm     (travelled_mm),
        .manual_mode      (manual_mode),
        .moving_in        (moving_in),
        .steer            (steer),
        .moving_out       (moving_out),
        .path_running     (path_running),
        .current_step     (current_step)
    );

endmodule

// File: dv/steering_predict_check.sv
`timescale 1ns / 1ps

module steering_predict_check
#(
    parameter int STEP_DEPTH = 256
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,

    input  logic               req_valid,
    input  logic               req_ready,
    input  logic               op,
    input  logic [7:0]         load_index,
    input  logic               load_last,
    input  logic [15:0]        load_distance_mm,
    input  logic signed [15:0] load_heading,
    input  logic [15:0]        delta_time_us,
    input  logic [23:0]        travelled_mm,
    input  logic               manual_mode,
    input  logic               moving_in,

    input  logic               rsp_valid,
    input  logic               rsp_ready,
    input  logic signed [7:0]  steer,
    input  logic               moving_out,
    input  logic               path_running,
    input  logic [8:0]         current_step,

    output int                 mismatches,
    output int                 results_checked,
    output int                 paths_started,
    output int                 steps_entered,
    output int                 integrations,
    output int                 overshoots
);

    localparam logic [2:0] TURN_RATE_ADDR = {pssc_pkg::REG_TURN_RATE, 2'b00};
    localparam longint HEADING_UNIT = longint'(1) << pssc_pkg::HEAD_SHIFT;
    localparam longint HALF_DEG     = longint'(180) << pssc_pkg::FRAC_BITS;
    localparam longint FULL_DEG     = longint'(360) << pssc_pkg::FRAC_BITS;
    localparam longint STEER_MAX    = longint'(80) << pssc_pkg::FRAC_BITS;
    localparam int     MAX_REPORTS  = 20;

    typedef struct {
        logic signed [7:0] steer;
        logic              moving;
        logic              running;
        logic [8:0]        step;
    } steer_result_t;

    steer_result_t expected_results[$];
    steer_result_t want;

    // controller copy
    logic [15:0]        turn_rate_q;
    logic [15:0]        step_len [STEP_DEPTH];
    logic signed [15:0] step_head [STEP_DEPTH];
    int unsigned        step_count;
    int unsigned        step_idx;
    bit                 path_armed;
    bit                 path_active;
    logic [24:0]        goal_mm;
    logic signed [15:0] goal_head;
    longint             est;
    longint             prev_gap;
    int                 steer_deg;

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // keep the low 40 bits, sign extended
    function automatic longint wrap40(input longint v);
        logic signed [39:0] low;
        low = v[39:0];
        return low;
    endfunction

    // new step: set goal, derive steering from the wrapped heading error
    function automatic void enter_step(input logic [23:0] trav);
        logic [15:0]        len;
        logic signed [15:0] head;
        longint             target;
        longint             diff;
        len = '0;
        head = '0;
        if (step_idx < STEP_DEPTH)
        begin
            len = step_len[step_idx];
            head = step_head[step_idx];
        end
        goal_mm = {1'b0, trav} + {9'd0, len};
        goal_head = head;
        target = longint'(head) * HEADING_UNIT;
        steps_entered++;
        if (step_idx == 0)
        begin
            est = target;
            steer_deg = 0;
            return;
        end
        diff = est - target;
        if (diff > HALF_DEG)
            diff -= FULL_DEG;
        else if (diff < -HALF_DEG)
            diff += FULL_DEG;
        if (goal_mm < pssc_pkg::GOAL_TRIPLE_BELOW)
            diff *= 3;
        else if (goal_mm < pssc_pkg::GOAL_DOUBLE_BELOW)
            diff *= 2;
        if (diff > STEER_MAX)
            diff = STEER_MAX;
        if (diff < -STEER_MAX)
            diff = -STEER_MAX;
        steer_deg = int'(magnitude(diff) >> pssc_pkg::FRAC_BITS);
        if (diff < 0)
            steer_deg = -steer_deg;
        prev_gap = magnitude(target - est);
    endfunction

    // one request in, one result out
    function automatic steer_result_t apply_request(
        input pssc_pkg::item_op_t kind,
        input logic [7:0]         idx,
        input logic               last_step,
        input logic [15:0]        len_mm,
        input logic signed [15:0] head,
        input logic [15:0]        dt_us,
        input logic [23:0]        trav,
        input logic               manual,
        input logic               moving);
        steer_result_t res;
        logic          mov;
        longint        prod;
        longint        target;
        longint        gap;
        mov = moving;
        if (kind == pssc_pkg::OP_LOAD)
        begin
            if (int'(idx) < STEP_DEPTH)
            begin
                step_len[idx] = len_mm;
                step_head[idx] = head;
                if (last_step)
                begin
                    step_count = int'(idx) + 1;
                    path_armed = 1'b1;
                end
            end
            mov = 1'b0;
        end
        else
        begin
            // an armed path starts even in manual mode
            if (path_armed)
            begin
                if (step_count > 0)
                begin
                    step_idx = 0;
                    enter_step(trav);
                    path_active = 1'b1;
                    paths_started++;
                end
                path_armed = 1'b0;
            end
            if (!manual)
            begin
                if (mov && !path_active)
                    mov = 1'b0;
                if (mov)
                begin
                    if ({1'b0, trav} >= goal_mm)
                    begin
                        step_idx++;
                        if (step_idx >= step_count)
                        begin
                            path_active = 1'b0;
                            mov = 1'b0;
                        end
                        else
                            enter_step(trav);
                    end
                    else if (steer_deg != 0)
                    begin
                        // integrate heading, recenter on overshoot
                        integrations++;
                        prod = longint'(turn_rate_q) * longint'(dt_us) * steer_deg;
                        target = longint'(goal_head) * HEADING_UNIT;
                        est = wrap40(est - prod);
                        gap = magnitude(target - est);
                        if (gap > prev_gap)
                        begin
                            est = target;
                            steer_deg = 0;
                            overshoots++;
                        end
                        else
                            prev_gap = gap;
                    end
                end
            end
        end
        res.steer = 8'(steer_deg);
        res.moving = mov;
        res.running = path_active;
        res.step = 9'(step_idx);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // watch config, requests and results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_rate_q = pssc_pkg::TURN_RATE_RESET;
            step_count = 0;
            step_idx = 0;
            path_armed = 1'b0;
            path_active = 1'b0;
            goal_mm = '0;
            goal_head = '0;
            est = 0;
            prev_gap = 0;
            steer_deg = 0;
            expected_results.delete();
            mismatches = 0;
            results_checked = 0;
            paths_started = 0;
            steps_entered = 0;
            integrations = 0;
            overshoots = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == TURN_RATE_ADDR)
                turn_rate_q = pwdata[15:0];

            if (req_valid && req_ready)
                expected_results.push_back(apply_request(pssc_pkg::item_op_t'(op),
                    load_index, load_last, load_distance_mm, load_heading, delta_time_us,
                    travelled_mm, manual_mode, moving_in));

            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (steer !== want.steer)
                        report_mismatch($sformatf("result %0d steer %0d, expected %0d",
                            results_checked, steer, want.steer));
                    if (moving_out !== want.moving)
                        report_mismatch($sformatf("result %0d moving_out %b, expected %b",
                            results_checked, moving_out, want.moving));
                    if (path_running !== want.running)
                        report_mismatch($sformatf("result %0d path_running %b, expected %b",
                            results_checked, path_running, want.running));
                    if (current_step !== want.step)
                        report_mismatch($sformatf("result %0d current_step %0d, expected %0d",
                            results_checked, current_step, want.step));
                end
            end
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int         ITEM_TARGET    = 1850;
    localparam int         PHASES         = 6;
    localparam int         CYCLE_LIMIT    = 1000000;
    localparam int         SETTLE_CYCLES  = 20;
    localparam logic [2:0] TURN_RATE_ADDR = {pssc_pkg::REG_TURN_RATE, 2'b00};

    typedef struct {
        pssc_pkg::item_op_t kind;
        logic [7:0]         idx;
        logic               last_step;
        logic [15:0]        len_mm;
        logic signed [15:0] head;
        logic [15:0]        dt_us;
        logic [23:0]        trav;
        logic               manual;
        logic               moving;
    } request_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    logic               req_valid = 1'b0;
    logic               req_ready;
    logic               op = 1'b0;
    logic [7:0]         load_index = '0;
    logic               load_last = 1'b0;
    logic [15:0]        load_distance_mm = '0;
    logic signed [15:0] load_heading = '0;
    logic [15:0]        delta_time_us = '0;
    logic [23:0]        travelled_mm = '0;
    logic               manual_mode = 1'b0;
    logic               moving_in = 1'b0;

    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    logic signed [7:0]  steer;
    logic               moving_out;
    logic               path_running;
    logic [8:0]         current_step;

    int                 mismatches;
    int                 results_checked;
    int                 paths_started;
    int                 steps_entered;
    int                 integrations;
    int                 overshoots;

    int                 requests_sent = 0;
    int                 cycles = 0;
    int                 stall_left = 0;
    bit                 idle_on = 1'b1;
    bit                 stall_on = 1'b1;
    bit                 step_loaded [256];

    path_step_steering_controller_top u_top (.*);

    steering_predict_check u_predict_check (.*);

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d of %0d results seen",
                cycles, results_checked, requests_sent);
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (stall_on && $urandom_range(0, 3) == 0)
        begin
            rsp_ready <= 1'b0;
            stall_left <= pick_gap();
        end
        else
            rsp_ready <= 1'b1;
    end

    function automatic request_t noise_req();
        request_t r;
        r.kind = pssc_pkg::item_op_t'($urandom_range(0, 1));
        r.idx = 8'($urandom);
        r.last_step = 1'($urandom);
        r.len_mm = 16'($urandom);
        r.head = 16'($urandom);
        r.dt_us = 16'($urandom);
        r.trav = 24'($urandom);
        r.manual = 1'($urandom);
        r.moving = 1'($urandom);
        return r;
    endfunction

    function automatic request_t load_req(input logic [7:0] idx, input logic last_step,
                                          input logic [15:0] len_mm,
                                          input logic signed [15:0] head);
        request_t r;
        r = noise_req();
        r.kind = pssc_pkg::OP_LOAD;
        r.idx = idx;
        r.last_step = last_step;
        r.len_mm = len_mm;
        r.head = head;
        return r;
    endfunction

    function automatic request_t tick_req(input logic [15:0] dt_us, input logic [23:0] trav,
                                          input logic manual, input logic moving);
        request_t r;
        r = noise_req();
        r.kind = pssc_pkg::OP_TICK;
        r.dt_us = dt_us;
        r.trav = trav;
        r.manual = manual;
        r.moving = moving;
        return r;
    endfunction

    // send one request; valid stays up across back-to-back requests
    task automatic push_req(input request_t r);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (r.kind == pssc_pkg::OP_LOAD)
        begin
            // a path may only end where every step below it holds data
            for (int i = 0; i < int'(r.idx); i++)
                if (!step_loaded[i])
                    r.last_step = 1'b0;
            step_loaded[r.idx] = 1'b1;
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        op <= r.kind;
        load_index <= r.idx;
        load_last <= r.last_step;
        load_distance_mm <= r.len_mm;
        load_heading <= r.head;
        delta_time_us <= r.dt_us;
        travelled_mm <= r.trav;
        manual_mode <= r.manual;
        moving_in <= r.moving;
        do
            @(posedge clk);
        while (!req_ready);
        requests_sent++;
    endtask

    // hold requests until every result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (results_checked < requests_sent)
            @(posedge clk);
    endtask

    task automatic write_turn_rate(input logic [15:0] rate);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TURN_RATE_ADDR;
        pwdata <= {16'd0, rate};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // load a path of n steps, then drive ticks along it
    task automatic drive_path(input int n_steps, input bit wide, input int n_ticks);
        logic signed [15:0] hd;
        logic [15:0]        len;
        logic [15:0]        dt_us;
        logic [23:0]        odo;
        int                 r;
        hd = 16'($urandom);
        for (int i = 0; i < n_steps; i++)
        begin
            // stray load somewhere in the table
            if ($urandom_range(0, 9) == 0)
                push_req(load_req(8'($urandom), 1'b0, 16'($urandom), 16'($urandom)));
            r = $urandom_range(0, wide ? 99 : 84);
            if (r < 15)
                len = '0;
            else if (r < 85)
                len = 16'($urandom_range(1, wide ? 30 : 4));
            else if (r < 95)
                len = 16'($urandom_range(31, 300));
            else
                len = 16'($urandom);
            r = $urandom_range(0, 9);
            if (r < 7)
                hd = hd + 16'($urandom_range(0, 5760)) - 16'd2880;
            else if (r < 9)
                hd = hd + 16'($urandom_range(0, 23040)) - 16'd11520;
            else
                hd = 16'($urandom);
            push_req(load_req(8'(i), i == n_steps - 1, len, hd));
        end
        odo = $urandom_range(0, 1) ? 24'($urandom_range(0, 12)) : 24'($urandom);
        repeat (n_ticks)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
                dt_us = '0;
            else if (r < 70)
                dt_us = 16'($urandom_range(1, 2000));
            else if (r < 95)
                dt_us = 16'($urandom_range(2001, 20000));
            else
                dt_us = 16'($urandom_range(60000, 65535));
            r = $urandom_range(0, 99);
            if (!wide)
                odo = odo + 24'($urandom_range(5, 30));
            else if (r >= 20 && r < 90)
                odo = odo + 24'($urandom_range(1, 25));
            else if (r >= 90 && r < 98)
                odo = odo + 24'($urandom_range(26, 200));
            else if (r >= 98)
                odo = 24'($urandom);
            r = $urandom_range(0, 99);
            push_req(tick_req(dt_us, odo, wide && r < 8, !wide || r < 95));
        end
    endtask

    // stimulus
    initial
    begin
        logic [15:0] rate;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no path yet: motion cleared, manual mode passes it through
        push_req(tick_req(16'd100, 24'd0, 1'b0, 1'b1));
        push_req(tick_req(16'd0, 24'd0, 1'b1, 1'b1));
        // extreme steps, wrap of a large heading error, full clamp
        push_req(load_req(8'd0, 1'b0, 16'd0, -16'sd32768));
        push_req(load_req(8'd1, 1'b0, 16'd65535, 16'sd32767));
        push_req(load_req(8'd2, 1'b0, 16'd3, 16'sd0));
        push_req(load_req(8'd3, 1'b1, 16'd7, 16'sd11520));
        // armed path starts in manual mode, then steps on
        push_req(tick_req(16'd0, 24'd0, 1'b1, 1'b0));
        push_req(tick_req(16'd65535, 24'd0, 1'b0, 1'b1));
        push_req(tick_req(16'd65535, 24'd100, 1'b0, 1'b1));
        push_req(tick_req(16'd65535, 24'd200, 1'b0, 1'b1));
        push_req(tick_req(16'd1, 24'hFFFFFF, 1'b0, 1'b1));
        push_req(tick_req(16'd0, 24'hFFFFFF, 1'b0, 1'b1));
        push_req(tick_req(16'd1000, 24'd0, 1'b0, 1'b0));
        // short goals: tripled and doubled error, re-armed while running
        push_req(load_req(8'd0, 1'b0, 16'd1, 16'sd0));
        push_req(load_req(8'd1, 1'b0, 16'd2, 16'sd640));
        push_req(load_req(8'd2, 1'b0, 16'd4, -16'sd1280));
        push_req(load_req(8'd3, 1'b1, 16'd9, 16'sd960));
        push_req(tick_req(16'd500, 24'd0, 1'b0, 1'b1));
        push_req(tick_req(16'd500, 24'd1, 1'b0, 1'b1));
        push_req(tick_req(16'd2000, 24'd2, 1'b0, 1'b1));
        push_req(tick_req(16'd2000, 24'd3, 1'b0, 1'b1));
        push_req(tick_req(16'd3000, 24'd7, 1'b0, 1'b1));
        push_req(tick_req(16'd0, 24'd16, 1'b0, 1'b1));
        push_req(tick_req(16'd0, 24'd20, 1'b0, 1'b1));
        // zero length first step passed on the starting tick
        push_req(load_req(8'd0, 1'b0, 16'd0, 16'sd5000));
        push_req(load_req(8'd1, 1'b1, 16'd30, -16'sd5000));
        push_req(tick_req(16'd100, 24'd50, 1'b0, 1'b1));

        // random paths, one turn rate per phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_results();
            case (ph)
                0: rate = 16'd65535;
                1: rate = 16'd1;
                2: rate = 16'd0;
                3: rate = 16'($urandom);
                4: rate = pssc_pkg::TURN_RATE_RESET;
                default: rate = 16'($urandom_range(100, 4000));
            endcase
            write_turn_rate(rate);
            // full table path walks current_step up to the end
            if (ph == 1)
            begin
                idle_on = 1'b1;
                stall_on = 1'b1;
                drive_path(256, 1'b0, 300);
            end
            while (requests_sent < ITEM_TARGET * (ph + 1) / PHASES)
            begin
                idle_on = $urandom_range(0, 3) != 0;
                stall_on = $urandom_range(0, 3) != 0;
                if ($urandom_range(0, 7) == 0)
                    drain_results();
                drive_path($urandom_range(1, 12), 1'b1, 0);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d requests over %0d turn rate settings: %0d paths started, %0d steps",
            requests_sent, PHASES + 1, paths_started, steps_entered);
        $display("heading integrated on %0d ticks, %0d overshoot recoveries",
            integrations, overshoots);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/pssc_pkg.sv
hdl/pssc_regs.sv
hdl/pssc_ctrl.sv
hdl/pssc_dp.sv
hdl/path_step_steering_controller_top.sv
dv/steering_predict_check.sv
dv/testbench.sv
